// ===== src/tepp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tepp_pkg;

    // Default configuration of the block.
    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register file: four words of the expected source identifier.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_ID_WORD0 = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_ID_WORD1 = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_ID_WORD2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_ID_WORD3 = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0] SOURCE_ID_WORD0_RESET = 32'hd2d578d9;
    localparam logic [CFG_DATA_BITS-1:0] SOURCE_ID_WORD1_RESET = 32'h293645b6;
    localparam logic [CFG_DATA_BITS-1:0] SOURCE_ID_WORD2_RESET = 32'ha09f30e3;
    localparam logic [CFG_DATA_BITS-1:0] SOURCE_ID_WORD3_RESET = 32'h2715f41d;

    // Input item kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    // Opcode layout.
    localparam int OP_STACK_BIT = 3;

    typedef enum logic [3:0] {
        TK_TYPE       = 4'd0,
        TK_NAME_CHAR  = 4'd1,
        TK_ID         = 4'd2,
        TK_CAT_CHAR   = 4'd3,
        TK_ARG_NAME   = 4'd4,
        TK_ARG_VALUE  = 4'd5,
        TK_STACK_CNT  = 4'd6,
        TK_STACK_WORD = 4'd7,
        TK_VERDICT    = 4'd8
    } token_kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_OTHER_SOURCE = 3'd1,
        ST_UNKNOWN_TYPE = 3'd2,
        ST_TRUNCATED    = 3'd3,
        ST_TRAILING     = 3'd4
    } status_t;

    typedef struct packed {
        token_kind_t kind;
        logic [63:0] value;
        logic        field_end;
        status_t     status;
        logic        last;
    } token_t;

    // One queue entry holds every token that a single input transaction causes.
    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   two;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/tepp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tepp_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  opcode;
    logic [15:0] payload_length;
    logic [31:0] id_word0;
    logic [31:0] id_word1;
    logic [31:0] id_word2;
    logic [31:0] id_word3;

    modport source (
        output valid, kind, data_byte, opcode, payload_length,
               id_word0, id_word1, id_word2, id_word3,
        input  ready
    );

    modport sink (
        input  valid, kind, data_byte, opcode, payload_length,
               id_word0, id_word1, id_word2, id_word3,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/tepp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tepp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic        field_end;
    logic [2:0]  status;
    logic        last;

    modport source (
        output valid, token_kind, token_value, field_end, status, last,
        input  ready
    );

    modport sink (
        input  valid, token_kind, token_value, field_end, status, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/tepp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Parser front end: takes one item a cycle while the queue has room, walks the payload
// fields and builds the tokens of that item as one queue entry.
module tepp_front #(
    parameter int LENGTH_BITS = tepp_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    tepp_in_if.sink                                in_ch,
    input  logic                                   cfg_we,
    input  logic [tepp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [tepp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   push_ready,
    output logic                                   push_valid,
    output tepp_pkg::entry_t                       push_entry
);

    localparam int SWL_BITS = LENGTH_BITS - 2;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_DRAIN = 8'b0000_0010,
        PH_NAME  = 8'b0000_0100,
        PH_ID    = 8'b0000_1000,
        PH_CAT   = 8'b0001_0000,
        PH_ARG   = 8'b0010_0000,
        PH_SCNT  = 8'b0100_0000,
        PH_SWORD = 8'b1000_0000
    } phase_t;

    logic [31:0] src_id0_reg, src_id1_reg, src_id2_reg, src_id3_reg;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [2:0]             args_left_reg, args_left_next;
    logic                   in_value_reg, in_value_next;
    logic                   stack_reg, stack_next;
    logic [2:0]             byte_index_reg, byte_index_next;
    logic [63:0]            acc_reg, acc_next;
    logic [SWL_BITS-1:0]    swl_reg, swl_next;

    logic                   accept;
    logic                   same_source;
    logic [3:0]             event_type;
    logic [LENGTH_BITS+15:0] len_ext;
    logic [LENGTH_BITS-1:0] len_hdr;
    logic [LENGTH_BITS-1:0] bytes_dec;
    logic [63:0]            acc_new;
    logic [31:0]            word;
    logic [33:0]            word_x4;
    logic [33:0]            room;
    logic                   term;
    logic                   strings_done;
    logic [2:0]             args_eff;
    logic                   fields_done;
    logic                   too_big;
    logic                   have_field;
    logic                   have_verdict;
    tepp_pkg::token_t       field_tok;
    tepp_pkg::status_t      verdict_status;
    tepp_pkg::token_kind_t  str_kind;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = push_ready;

    assign same_source = (in_ch.id_word0 == src_id0_reg) && (in_ch.id_word1 == src_id1_reg)
                      && (in_ch.id_word2 == src_id2_reg) && (in_ch.id_word3 == src_id3_reg);
    assign event_type  = in_ch.opcode[7:4];
    assign len_ext     = {{LENGTH_BITS{1'b0}}, in_ch.payload_length};
    assign len_hdr     = len_ext[LENGTH_BITS-1:0];
    assign bytes_dec   = bytes_left_reg - 1'b1;
    assign acc_new     = acc_reg | (64'(in_ch.data_byte) << {byte_index_reg, 3'b000});
    assign word        = acc_new[31:0];
    assign word_x4     = {word, 2'b00};
    assign room        = 34'(bytes_dec);
    assign term        = (in_ch.data_byte == 8'd0) || (bytes_left_reg == LENGTH_BITS'(1));

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        args_left_next  = args_left_reg;
        in_value_next   = in_value_reg;
        stack_next      = stack_reg;
        byte_index_next = byte_index_reg;
        acc_next        = acc_reg;
        swl_next        = swl_reg;
        field_tok       = '0;
        have_field      = 1'b0;
        have_verdict    = 1'b0;
        verdict_status  = tepp_pkg::ST_OK;
        strings_done    = 1'b0;
        args_eff        = args_left_reg;
        fields_done     = 1'b0;
        too_big         = 1'b0;
        str_kind        = tepp_pkg::TK_NAME_CHAR;

        if (in_ch.kind == tepp_pkg::KIND_HEADER)
        begin
            bytes_left_next = len_hdr;
            args_left_next  = in_ch.opcode[2:0];
            stack_next      = in_ch.opcode[tepp_pkg::OP_STACK_BIT];
            in_value_next   = 1'b0;
            byte_index_next = '0;
            acc_next        = '0;
            swl_next        = '0;
            if (!same_source)
            begin
                have_verdict   = 1'b1;
                verdict_status = tepp_pkg::ST_OTHER_SOURCE;
            end
            else if (event_type == 4'd0)
            begin
                have_verdict   = 1'b1;
                verdict_status = tepp_pkg::ST_UNKNOWN_TYPE;
            end
            else
            begin
                have_field       = 1'b1;
                field_tok.kind   = tepp_pkg::TK_TYPE;
                field_tok.value  = 64'(event_type);
                phase_next       = PH_NAME;
                if (len_hdr == '0)
                begin
                    have_verdict   = 1'b1;
                    verdict_status = tepp_pkg::ST_TRUNCATED;
                end
            end
            if (have_verdict)
            begin
                phase_next = (len_hdr != '0) ? PH_DRAIN : PH_IDLE;
            end
        end
        else if (phase_reg == PH_IDLE || bytes_left_reg == '0)
        begin
            // A stray byte outside any event is dropped.
            if (bytes_left_reg == '0)
            begin
                phase_next = PH_IDLE;
            end
        end
        else if (phase_reg == PH_DRAIN)
        begin
            bytes_left_next = bytes_dec;
            if (bytes_dec == '0)
            begin
                phase_next = PH_IDLE;
            end
        end
        else
        begin
            case (phase_reg)
                PH_NAME, PH_CAT, PH_ARG:
                begin
                    if (phase_reg == PH_NAME)
                        str_kind = tepp_pkg::TK_NAME_CHAR;
                    else if (phase_reg == PH_CAT)
                        str_kind = tepp_pkg::TK_CAT_CHAR;
                    else if (in_value_reg)
                        str_kind = tepp_pkg::TK_ARG_VALUE;
                    else
                        str_kind = tepp_pkg::TK_ARG_NAME;
                    have_field     = 1'b1;
                    field_tok.kind = str_kind;
                    if (term)
                    begin
                        field_tok.field_end = 1'b1;
                        if (phase_reg == PH_NAME)
                        begin
                            phase_next      = PH_ID;
                            byte_index_next = '0;
                            acc_next        = '0;
                        end
                        else if (phase_reg == PH_CAT)
                        begin
                            strings_done = 1'b1;
                        end
                        else if (!in_value_reg)
                        begin
                            in_value_next = 1'b1;
                        end
                        else
                        begin
                            args_eff       = args_left_reg - 1'b1;
                            args_left_next = args_eff;
                            strings_done   = 1'b1;
                        end
                    end
                    else
                    begin
                        field_tok.value = 64'(in_ch.data_byte);
                    end
                end
                PH_ID:
                begin
                    acc_next = acc_new;
                    if (byte_index_reg == 3'd7)
                    begin
                        have_field      = 1'b1;
                        field_tok.kind  = tepp_pkg::TK_ID;
                        field_tok.value = acc_new;
                        phase_next      = PH_CAT;
                        byte_index_next = '0;
                    end
                    else
                    begin
                        byte_index_next = byte_index_reg + 1'b1;
                    end
                end
                PH_SCNT, PH_SWORD:
                begin
                    if (byte_index_reg >= 3'd3)
                    begin
                        byte_index_next = '0;
                        acc_next        = '0;
                        have_field      = 1'b1;
                        field_tok.value = 64'(word);
                        if (phase_reg == PH_SCNT)
                        begin
                            field_tok.kind = tepp_pkg::TK_STACK_CNT;
                            swl_next       = word[SWL_BITS-1:0];
                            too_big        = word_x4 > room;
                            if (word == 32'd0)
                                fields_done = 1'b1;
                            else
                                phase_next = PH_SWORD;
                        end
                        else
                        begin
                            field_tok.kind = tepp_pkg::TK_STACK_WORD;
                            swl_next       = swl_reg - 1'b1;
                            if (swl_reg == {{(SWL_BITS-1){1'b0}}, 1'b1})
                                fields_done = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next        = acc_new;
                        byte_index_next = byte_index_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (strings_done)
            begin
                if (args_eff != 3'd0)
                begin
                    phase_next    = PH_ARG;
                    in_value_next = 1'b0;
                end
                else if (stack_reg)
                begin
                    phase_next      = PH_SCNT;
                    byte_index_next = '0;
                    acc_next        = '0;
                end
                else
                begin
                    fields_done = 1'b1;
                end
            end

            bytes_left_next = bytes_dec;
            if (too_big)
            begin
                have_verdict   = 1'b1;
                verdict_status = tepp_pkg::ST_TRUNCATED;
            end
            else if (fields_done)
            begin
                have_verdict   = 1'b1;
                verdict_status = (bytes_dec != '0) ? tepp_pkg::ST_TRAILING : tepp_pkg::ST_OK;
            end
            else if (bytes_dec == '0)
            begin
                have_verdict   = 1'b1;
                verdict_status = tepp_pkg::ST_TRUNCATED;
            end
            if (have_verdict)
            begin
                phase_next = (bytes_dec != '0) ? PH_DRAIN : PH_IDLE;
            end
        end
    end

    // Pack the field token first and the verdict after it.
    always_comb
    begin
        push_entry = '0;
        if (have_field)
        begin
            push_entry.tok0      = field_tok;
            push_entry.tok0.last = !have_verdict;
            if (have_verdict)
            begin
                push_entry.two         = 1'b1;
                push_entry.tok1.kind   = tepp_pkg::TK_VERDICT;
                push_entry.tok1.status = verdict_status;
                push_entry.tok1.last   = 1'b1;
            end
        end
        else
        begin
            push_entry.tok0.kind   = tepp_pkg::TK_VERDICT;
            push_entry.tok0.status = verdict_status;
            push_entry.tok0.last   = 1'b1;
        end
    end

    assign push_valid = accept && (have_field || have_verdict);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_id0_reg <= tepp_pkg::SOURCE_ID_WORD0_RESET;
            src_id1_reg <= tepp_pkg::SOURCE_ID_WORD1_RESET;
            src_id2_reg <= tepp_pkg::SOURCE_ID_WORD2_RESET;
            src_id3_reg <= tepp_pkg::SOURCE_ID_WORD3_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tepp_pkg::CFG_SOURCE_ID_WORD0: src_id0_reg <= cfg_data;
                tepp_pkg::CFG_SOURCE_ID_WORD1: src_id1_reg <= cfg_data;
                tepp_pkg::CFG_SOURCE_ID_WORD2: src_id2_reg <= cfg_data;
                tepp_pkg::CFG_SOURCE_ID_WORD3: src_id3_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            args_left_reg  <= '0;
            in_value_reg   <= 1'b0;
            stack_reg      <= 1'b0;
            byte_index_reg <= '0;
            acc_reg        <= '0;
            swl_reg        <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            args_left_reg  <= args_left_next;
            in_value_reg   <= in_value_next;
            stack_reg      <= stack_next;
            byte_index_reg <= byte_index_next;
            acc_reg        <= acc_next;
            swl_reg        <= swl_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tepp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Small entry queue between the parser and the token serializer.
module tepp_queue #(
    parameter int DEPTH = tepp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tepp_pkg::entry_t push_data,
    output logic             full,
    output logic             head_valid,
    output tepp_pkg::entry_t head_data,
    input  logic             pop
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    tepp_pkg::entry_t      mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == COUNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tepp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Token serializer: hands out the one or two tokens of the head entry.
module tepp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  tepp_pkg::entry_t head_data,
    output logic             pop,
    tepp_out_if.source       out_ch
);

    logic             second_reg, second_next;
    logic             take;
    tepp_pkg::token_t cur;

    assign cur  = second_reg ? head_data.tok1 : head_data.tok0;
    assign take = out_ch.valid && out_ch.ready;

    assign out_ch.valid       = head_valid;
    assign out_ch.token_kind  = cur.kind;
    assign out_ch.token_value = cur.value;
    assign out_ch.field_end   = cur.field_end;
    assign out_ch.status      = cur.status;
    assign out_ch.last        = cur.last;

    always_comb
    begin
        pop         = 1'b0;
        second_next = second_reg;
        if (take)
        begin
            if (!second_reg && head_data.two)
            begin
                second_next = 1'b1;
            end
            else
            begin
                pop         = 1'b1;
                second_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else
            second_reg <= second_next;
    end

endmodule

`default_nettype wire

// ===== src/trace_event_payload_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Transaction
// in_ch     sink       one event header or one payload byte
// out_ch    source     one token: field, character, id, stack value or verdict
// cfg       write      one 32-bit word of the expected source identifier
//
// An input transaction is parsed in the cycle it is accepted, so one item per clock
// is taken while the QUEUE_DEPTH-entry queue has room; its tokens go into the queue
// as one entry and are offered once it reaches the head. An item yields zero, one or
// two tokens and the output sends one token per cycle while out_ch.ready is high.
// Output stalls fill the queue and then hold in_ch.ready low. Reset clears the
// parser to idle, empties the queue and loads the default source identifier.
module trace_event_payload_parser_unit #(
    parameter int LENGTH_BITS = tepp_pkg::LENGTH_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = tepp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tepp_in_if.sink                             in_ch,
    tepp_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [tepp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tepp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // The front end parses and packs the tokens of one item into an entry.
    logic             push_valid;
    tepp_pkg::entry_t push_entry;
    logic             queue_full;

    // The back end drains entries token by token.
    logic             head_valid;
    tepp_pkg::entry_t head_data;
    logic             pop;

    tepp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_ready (!queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    tepp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_data  (push_entry),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    tepp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the trace event payload parser.
//
// An initial block builds the stimulus: a short directed opening, then four
// rounds of random events, each round under its own expected source
// identifier and its own pattern of sender gaps and receiver stalls. The
// items go into a queue that a clocked driver empties onto the input channel.
// Every accepted input transaction is run through a local parser model that
// appends the tokens it should cause to a queue. A clocked monitor takes
// each output transaction and compares it field by field with the oldest
// token in that queue.
module tb_top;

    // One input item as it travels on the input channel.
    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic [7:0]       opcode;
        logic [15:0]      payload_length;
        logic [3:0][31:0] id_words;
    } parser_item_t;

    // Where the local parser model stands inside the current event.
    typedef enum logic [3:0] {
        WALK_IDLE,
        WALK_DRAIN,
        WALK_NAME,
        WALK_ID,
        WALK_CAT,
        WALK_ARG,
        WALK_SCNT,
        WALK_SWORD,
        WALK_DONE
    } walk_phase_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [tepp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [tepp_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    tepp_in_if  in_ch ();
    tepp_out_if out_ch ();

    trace_event_payload_parser_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Items waiting to be driven, and tokens waiting to be seen.
    parser_item_t     stimulus_items[$];
    tepp_pkg::token_t expected_tokens[$];
    logic [7:0]       payload_bytes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int event_items;
    int tokens_this_item;

    // State of the local parser model; the identifier copy follows every
    // register write that the bench makes.
    logic [3:0][31:0] source_id;
    walk_phase_t      walk_phase;
    logic [15:0]      bytes_left;
    logic [2:0]       args_left;
    logic             in_value_string;
    logic             stack_present;
    logic [2:0]       byte_index;
    logic [63:0]      word_acc;
    logic [31:0]      stack_words_left;

    task automatic push_token(input tepp_pkg::token_kind_t k, input logic [63:0] v,
                              input logic e, input tepp_pkg::status_t s);
        tepp_pkg::token_t t;
        t.kind      = k;
        t.value     = v;
        t.field_end = e;
        t.status    = s;
        t.last      = 1'b0;
        expected_tokens.push_back(t);
        tokens_this_item++;
    endtask

    // A verdict closes the event. Whatever payload is still announced is
    // swallowed silently afterwards.
    task automatic close_event(input tepp_pkg::status_t s);
        walk_phase = (bytes_left != 0) ? WALK_DRAIN : WALK_IDLE;
        push_token(tepp_pkg::TK_VERDICT, 64'd0, 1'b0, s);
    endtask

    // After the categories string or a finished argument pair, the next
    // field is another argument, the stack, or nothing at all.
    task automatic next_after_strings();
        if (args_left != 0)
        begin
            walk_phase      = WALK_ARG;
            in_value_string = 1'b0;
        end
        else if (stack_present)
        begin
            walk_phase = WALK_SCNT;
            byte_index = '0;
            word_acc   = '0;
        end
        else
        begin
            walk_phase = WALK_DONE;
        end
    endtask

    // Advances the parser model by one accepted input transaction and queues
    // the tokens it causes, marking the final one.
    task automatic predict_tokens(input parser_item_t it);
        logic                  too_big;
        logic                  term;
        logic [7:0]            b;
        logic [31:0]           w;
        tepp_pkg::token_kind_t k;
        tepp_pkg::token_t      final_tok;
        tokens_this_item = 0;
        too_big          = 1'b0;
        b                = it.data_byte;
        if (it.kind == tepp_pkg::KIND_HEADER)
        begin
            // A header always restarts the walk, even in the middle of an event.
            bytes_left       = it.payload_length;
            args_left        = it.opcode[2:0];
            stack_present    = it.opcode[tepp_pkg::OP_STACK_BIT];
            in_value_string  = 1'b0;
            byte_index       = '0;
            word_acc         = '0;
            stack_words_left = '0;
            if (it.id_words != source_id)
            begin
                close_event(tepp_pkg::ST_OTHER_SOURCE);
            end
            else if (it.opcode[7:4] == 4'd0)
            begin
                close_event(tepp_pkg::ST_UNKNOWN_TYPE);
            end
            else
            begin
                push_token(tepp_pkg::TK_TYPE, 64'(it.opcode[7:4]), 1'b0, tepp_pkg::ST_OK);
                walk_phase = WALK_NAME;
                if (bytes_left == 0)
                    close_event(tepp_pkg::ST_TRUNCATED);
            end
        end
        else if (walk_phase == WALK_IDLE || walk_phase == WALK_DONE || bytes_left == 0)
        begin
            if (bytes_left == 0)
                walk_phase = WALK_IDLE;
        end
        else if (walk_phase == WALK_DRAIN)
        begin
            bytes_left--;
            if (bytes_left == 0)
                walk_phase = WALK_IDLE;
        end
        else
        begin
            // A string also ends on the last announced byte of the payload.
            term = (b == 8'd0) || (bytes_left == 16'd1);
            case (walk_phase)
                WALK_NAME, WALK_CAT, WALK_ARG:
                begin
                    k = (walk_phase == WALK_NAME) ? tepp_pkg::TK_NAME_CHAR :
                        (walk_phase == WALK_CAT)  ? tepp_pkg::TK_CAT_CHAR  :
                        in_value_string           ? tepp_pkg::TK_ARG_VALUE :
                                                    tepp_pkg::TK_ARG_NAME;
                    if (term)
                    begin
                        push_token(k, 64'd0, 1'b1, tepp_pkg::ST_OK);
                        if (walk_phase == WALK_NAME)
                        begin
                            walk_phase = WALK_ID;
                            byte_index = '0;
                            word_acc   = '0;
                        end
                        else if (walk_phase == WALK_CAT)
                        begin
                            next_after_strings();
                        end
                        else if (!in_value_string)
                        begin
                            in_value_string = 1'b1;
                        end
                        else
                        begin
                            args_left--;
                            next_after_strings();
                        end
                    end
                    else
                    begin
                        push_token(k, 64'(b), 1'b0, tepp_pkg::ST_OK);
                    end
                end
                WALK_ID:
                begin
                    word_acc |= 64'(b) << (8 * byte_index);
                    if (byte_index == 3'd7)
                    begin
                        push_token(tepp_pkg::TK_ID, word_acc, 1'b0, tepp_pkg::ST_OK);
                        walk_phase = WALK_CAT;
                        byte_index = '0;
                    end
                    else
                    begin
                        byte_index++;
                    end
                end
                WALK_SCNT, WALK_SWORD:
                begin
                    word_acc |= 64'(b) << (8 * byte_index[1:0]);
                    if (byte_index >= 3'd3)
                    begin
                        w          = word_acc[31:0];
                        byte_index = '0;
                        word_acc   = '0;
                        if (walk_phase == WALK_SCNT)
                        begin
                            push_token(tepp_pkg::TK_STACK_CNT, 64'(w), 1'b0, tepp_pkg::ST_OK);
                            stack_words_left = w;
                            // The count is checked against what remains after
                            // its own last byte.
                            too_big    = (64'(w) * 64'd4) > (64'(bytes_left) - 64'd1);
                            walk_phase = (w == 0) ? WALK_DONE : WALK_SWORD;
                        end
                        else
                        begin
                            push_token(tepp_pkg::TK_STACK_WORD, 64'(w), 1'b0, tepp_pkg::ST_OK);
                            stack_words_left--;
                            if (stack_words_left == 0)
                                walk_phase = WALK_DONE;
                        end
                    end
                    else
                    begin
                        byte_index++;
                    end
                end
                default:
                begin
                end
            endcase
            bytes_left--;
            if (too_big)
                close_event(tepp_pkg::ST_TRUNCATED);
            else if (walk_phase == WALK_DONE)
                close_event((bytes_left != 0) ? tepp_pkg::ST_TRAILING : tepp_pkg::ST_OK);
            else if (bytes_left == 0)
                close_event(tepp_pkg::ST_TRUNCATED);
        end
        if (tokens_this_item > 0)
        begin
            final_tok      = expected_tokens.pop_back();
            final_tok.last = 1'b1;
            expected_tokens.push_back(final_tok);
        end
    endtask

    // Header fields of a byte item are don't-care, so they carry random noise,
    // and the payload byte of a header does too.
    task automatic add_header(input logic [7:0] op, input logic [15:0] len,
                              input logic [3:0][31:0] ids);
        parser_item_t it;
        it                = '0;
        it.kind           = tepp_pkg::KIND_HEADER;
        it.data_byte      = 8'($urandom);
        it.opcode         = op;
        it.payload_length = len;
        it.id_words       = ids;
        stimulus_items.push_back(it);
    endtask

    task automatic add_byte(input logic [7:0] b);
        parser_item_t it;
        it                = '0;
        it.kind           = tepp_pkg::KIND_BYTE;
        it.data_byte      = b;
        it.opcode         = 8'($urandom);
        it.payload_length = 16'($urandom);
        it.id_words       = {$urandom, $urandom, $urandom, $urandom};
        stimulus_items.push_back(it);
    endtask

    // A string of up to five nonzero characters, usually closed by a zero.
    task automatic add_string();
        repeat ($urandom_range(5))
            payload_bytes.push_back(8'($urandom_range(255, 1)));
        if ($urandom_range(9) != 0)
            payload_bytes.push_back(8'd0);
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            payload_bytes.push_back(w[8*i +: 8]);
    endtask

    // Builds one event: mostly a well formed payload under the configured
    // identifier, sometimes with a wrong identifier or type zero, and with the
    // announced length exact, short, long or cut off by the next header.
    task automatic add_random_event();
        logic [3:0][31:0] ids;
        logic [7:0]       op;
        logic [31:0]      stack_count;
        int               shape;
        int               full_len;
        int               length;
        int               sent_len;
        ids = source_id;
        op  = 8'($urandom);
        if (op[7:4] == 4'd0)
            op[7:4] = 4'($urandom_range(15, 1));
        if ($urandom_range(3) != 0)
            op[2:0] = 3'($urandom_range(2));
        shape = $urandom_range(99);
        if (shape < 4)
            ids[$urandom_range(3)] ^= 32'd1 << $urandom_range(31);
        else if (shape < 8)
            op[7:4] = 4'd0;

        payload_bytes.delete();
        add_string();
        repeat (8)
            payload_bytes.push_back(8'($urandom));
        add_string();
        repeat (2 * op[2:0])
            add_string();
        if (op[tepp_pkg::OP_STACK_BIT])
        begin
            // Now and then a count far beyond what the payload can hold.
            stack_count = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(3));
            add_word(stack_count);
            if (stack_count <= 32'd3)
            begin
                repeat (int'(stack_count))
                    add_word($urandom);
            end
            else
            begin
                repeat ($urandom_range(3))
                    payload_bytes.push_back(8'($urandom));
            end
        end
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(3, 1))
                payload_bytes.push_back(8'($urandom));
        end
        full_len = payload_bytes.size();

        shape = $urandom_range(99);
        if (shape < 70)
        begin
            length   = full_len;
            sent_len = full_len;
        end
        else if (shape < 85)
        begin
            length   = $urandom_range(full_len);
            sent_len = length;
        end
        else if (shape < 93)
        begin
            length   = full_len + $urandom_range(4, 1);
            sent_len = length;
        end
        else
        begin
            // The next header breaks into this event before it is over.
            length   = ($urandom_range(1) == 0) ? $urandom_range(65535) : full_len + 5;
            sent_len = $urandom_range(full_len);
        end

        add_header(op, 16'(length), ids);
        for (int i = 0; i < sent_len; i++)
            add_byte((i < full_len) ? payload_bytes[i] : 8'($urandom));
        event_items += 1 + sent_len;
    endtask

    // Register writes happen only while the parser is idle, one word per clock.
    task automatic load_source_id(input logic [3:0][31:0] value);
        logic [tepp_pkg::CFG_INDEX_BITS-1:0] reg_index [4];
        reg_index = '{tepp_pkg::CFG_SOURCE_ID_WORD0, tepp_pkg::CFG_SOURCE_ID_WORD1,
                      tepp_pkg::CFG_SOURCE_ID_WORD2, tepp_pkg::CFG_SOURCE_ID_WORD3};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we       <= 1'b1;
            cfg_index    <= reg_index[i];
            cfg_data     <= value[i];
            source_id[i]  = value[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every item has been taken and every token has come back.
    // The check sits on the falling edge, away from any update. Some bytes
    // cause no token, so the task then lets the block settle before it returns.
    task automatic wait_until_quiet(input int settle_cycles);
        while (stimulus_items.size() != 0 || in_ch.valid || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic run_round(input int send_pct, input int recv_pct, input int item_goal);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        event_items    = 0;
        while (event_items < item_goal)
        begin
            add_random_event();
            // Noise: a stray byte, or a random header with up to three bytes behind it.
            if ($urandom_range(19) == 0)
            begin
                if ($urandom_range(1) == 0)
                begin
                    add_byte(8'($urandom));
                end
                else
                begin
                    add_header(8'($urandom), 16'($urandom),
                               {$urandom, $urandom, $urandom, $urandom});
                    repeat ($urandom_range(3))
                        add_byte(8'($urandom));
                end
            end
        end
        wait_until_quiet(8);
    endtask

    // Driver: the model sees each input transaction at the edge that accepts
    // it; a new item goes out whenever the channel is free and no gap is drawn.
    always @(posedge clk)
    begin : drive_inputs
        parser_item_t seen;
        parser_item_t next_item;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                seen.kind           = in_ch.kind;
                seen.data_byte      = in_ch.data_byte;
                seen.opcode         = in_ch.opcode;
                seen.payload_length = in_ch.payload_length;
                seen.id_words       = {in_ch.id_word3, in_ch.id_word2,
                                       in_ch.id_word1, in_ch.id_word0};
                predict_tokens(seen);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (stimulus_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item             = stimulus_items.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.kind           <= next_item.kind;
                    in_ch.data_byte      <= next_item.data_byte;
                    in_ch.opcode         <= next_item.opcode;
                    in_ch.payload_length <= next_item.payload_length;
                    in_ch.id_word0       <= next_item.id_words[0];
                    in_ch.id_word1       <= next_item.id_words[1];
                    in_ch.id_word2       <= next_item.id_words[2];
                    in_ch.id_word3       <= next_item.id_words[3];
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every output transaction must match the oldest expected token.
    always @(posedge clk)
    begin : check_tokens
        tepp_pkg::token_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token: token_kind %0d token_value %0h status %0d",
                       out_ch.token_kind, out_ch.token_value, out_ch.status);
                error_count++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (out_ch.token_kind !== want.kind)
                begin
                    $error("token_kind: expected %0d, actual %0d", want.kind, out_ch.token_kind);
                    error_count++;
                end
                if (out_ch.token_value !== want.value)
                begin
                    $error("token_value: expected %0h, actual %0h",
                           want.value, out_ch.token_value);
                    error_count++;
                end
                if (out_ch.field_end !== want.field_end)
                begin
                    $error("field_end: expected %0d, actual %0d",
                           want.field_end, out_ch.field_end);
                    error_count++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, out_ch.last);
                    error_count++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : stimulus
        logic [3:0][31:0] ok_ids;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = tepp_pkg::CFG_SOURCE_ID_WORD0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.kind           = tepp_pkg::KIND_HEADER;
        in_ch.data_byte      = '0;
        in_ch.opcode         = '0;
        in_ch.payload_length = '0;
        in_ch.id_word0       = '0;
        in_ch.id_word1       = '0;
        in_ch.id_word2       = '0;
        in_ch.id_word3       = '0;
        out_ch.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        error_count          = 0;
        event_items          = 0;
        source_id            = {tepp_pkg::SOURCE_ID_WORD3_RESET,
                                tepp_pkg::SOURCE_ID_WORD2_RESET,
                                tepp_pkg::SOURCE_ID_WORD1_RESET,
                                tepp_pkg::SOURCE_ID_WORD0_RESET};
        walk_phase           = WALK_IDLE;
        bytes_left           = '0;
        args_left            = '0;
        in_value_string      = 1'b0;
        stack_present        = 1'b0;
        byte_index           = '0;
        word_acc             = '0;
        stack_words_left     = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset identifier, with no gaps or stalls.
        ok_ids = source_id;
        // Foreign source with every opcode bit set and the longest payload;
        // one byte is drained before a new header cuts the drain short.
        add_header(8'hFF, 16'hFFFF, {4{32'hFFFF_FFFF}});
        add_byte(8'h00);
        // Event type zero with two bytes that are drained, then a stray byte
        // that arrives while idle.
        add_header(8'h0F, 16'd2, ok_ids);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(8'h5A);
        // Empty payload: type token and an immediate truncated verdict.
        add_header(8'hF0, 16'd0, ok_ids);
        // Short complete event: one-letter name, id, empty categories.
        add_header(8'h10, 16'd11, ok_ids);
        add_byte(8'h41);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'h03);
        add_byte(8'h04);
        add_byte(8'h05);
        add_byte(8'h06);
        add_byte(8'h80);
        add_byte(8'h00);
        // Payload that ends inside the id.
        add_header(8'h29, 16'd3, ok_ids);
        add_byte(8'h00);
        add_byte(8'h11);
        add_byte(8'h22);
        wait_until_quiet(8);

        // Random rounds; each one after the first brings a new identifier and idling pattern.
        run_round(0, 0, 200);
        load_source_id('0);
        run_round(84, 0, 200);
        load_source_id({4{32'hFFFF_FFFF}});
        run_round(0, 84, 200);
        load_source_id({$urandom, $urandom, $urandom, $urandom});
        run_round(22, 22, 200);

        wait_until_quiet(20);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tepp_pkg.sv
src/tepp_in_if.sv
src/tepp_out_if.sv
src/tepp_front.sv
src/tepp_queue.sv
src/tepp_back.sv
src/trace_event_payload_parser_unit.sv
verif/tb_top.sv
